// File: design/lscc_pkg.sv
// Package for the line-sensor calibrate/classify block.
// Holds shared constants, item kind codes, the controller state type and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lscc_pkg;

   localparam int CHANNELS_DEFAULT    = 5;
   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int KIND_BITS           = 2;
   localparam int CHANNEL_BITS        = 3;
   localparam int PERCENT_BITS        = 7;
   localparam int MARK_RESET_HIGH     = 1023;

   localparam logic [PERCENT_BITS-1:0] FULL_SCALE = 7'd100;

   localparam logic [KIND_BITS-1:0] KIND_BLACK   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_WHITE   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_MEASURE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: design/lscc_ifs.sv
// Valid/ready channel interfaces for the line-sensor block: request and response.
// Depends on lscc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lscc_req_if #(
   parameter int SAMPLE_BITS = lscc_pkg::SAMPLE_BITS_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic [lscc_pkg::KIND_BITS-1:0]    kind;
   logic [lscc_pkg::CHANNEL_BITS-1:0] channel;
   logic [SAMPLE_BITS-1:0]            sample;

   modport source (output valid, kind, channel, sample, input ready);
   modport sink   (input valid, kind, channel, sample, output ready);
endinterface

interface lscc_rsp_if #(
   parameter int SAMPLE_BITS = lscc_pkg::SAMPLE_BITS_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic                              channel_valid;
   logic                              on_line;
   logic [SAMPLE_BITS-1:0]            threshold;
   logic [lscc_pkg::PERCENT_BITS-1:0] percent;
   logic                              range_error;

   modport source (output valid, channel_valid, on_line, threshold, percent, range_error,
                   input ready);
   modport sink   (input valid, channel_valid, on_line, threshold, percent, range_error,
                   output ready);
endinterface

`default_nettype wire

// File: design/lscc_ctrl.sv
// Controller state machine of the line-sensor block: sequences capture,
// calibration update, the shift-subtract divide and the result load.
// Depends on lscc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lscc_ctrl #(
   parameter int SAMPLE_BITS = lscc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  lscc_pkg::dp_status_type status,
   output lscc_pkg::ctrl_cmd_type  cmd
);
   import lscc_pkg::*;

   // The quotient has one bit per divide step.
   localparam int QUO_BITS = SAMPLE_BITS + PERCENT_BITS;
   localparam int CNT_BITS = $clog2(QUO_BITS);

   ctrl_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 last_step;

   assign last_step = (count_ff == CNT_BITS'(QUO_BITS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = status.need_div ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            if (last_step) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      count_in     = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CALC: begin
            cmd.update = 1'b1;
            count_in   = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
         end
         ST_FINISH: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: design/lscc_dp.sv
// Datapath of the line-sensor block: per-channel low/high/threshold marks,
// percentage divider and the response register. Depends on lscc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lscc_dp #(
   parameter int CHANNELS    = lscc_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = lscc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  lscc_pkg::ctrl_cmd_type                cmd,
   output lscc_pkg::dp_status_type               status,
   input  wire  [lscc_pkg::KIND_BITS-1:0]        req_kind,
   input  wire  [lscc_pkg::CHANNEL_BITS-1:0]     req_channel,
   input  wire  [SAMPLE_BITS-1:0]                req_sample,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic                                  rsp_channel_valid,
   output logic                                  rsp_on_line,
   output logic [SAMPLE_BITS-1:0]                rsp_threshold,
   output logic [lscc_pkg::PERCENT_BITS-1:0]     rsp_percent,
   output logic                                  rsp_range_error
);
   import lscc_pkg::*;

   localparam int SB       = SAMPLE_BITS;
   localparam int QUO_BITS = SB + PERCENT_BITS;
   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [SB-1:0] RST_HIGH = SB'(MARK_RESET_HIGH);
   localparam logic [SB-1:0] RST_THR  = RST_HIGH >> 1;

   // Captured request.
   logic [KIND_BITS-1:0]    kind_ff;
   logic [CHANNEL_BITS-1:0] chan_ff;
   logic [SB-1:0]           sample_ff;

   // Per-channel marks.
   logic [SB-1:0] low_ff  [CHANNELS];
   logic [SB-1:0] high_ff [CHANNELS];
   logic [SB-1:0] thr_ff  [CHANNELS];

   // Intermediate result and divider.
   logic                  chan_ok_ff;
   logic                  on_ff;
   logic [SB-1:0]         thr_res_ff;
   logic                  err_ff;
   logic                  need_div_ff;
   logic [SB-1:0]         divisor_ff;
   logic [SB:0]           rem_ff;
   logic [QUO_BITS-1:0]   quo_ff;

   // Response register.
   logic                    out_valid_ff;
   logic                    out_chan_ok_ff;
   logic                    out_on_ff;
   logic [SB-1:0]           out_thr_ff;
   logic [PERCENT_BITS-1:0] out_pct_ff;
   logic                    out_err_ff;

   logic [IDX_BITS-1:0] idx;
   logic                chan_ok;
   logic                is_black, is_white, is_meas, is_calib;
   logic [SB-1:0]       lo_cur, hi_cur, thr_cur;
   logic [SB-1:0]       lo_new, hi_new, thr_new;
   logic [SB:0]         mid_sum;
   logic                err_new;
   logic [SB-1:0]       diff;
   logic [QUO_BITS-1:0] dividend;
   logic [SB:0]         trial;
   logic                trial_ge;
   logic                saturated;
   logic [PERCENT_BITS-1:0] pct_fin;

   assign idx      = chan_ff[IDX_BITS-1:0];
   assign chan_ok  = ({1'b0, chan_ff} < (CHANNEL_BITS + 1)'(CHANNELS));
   assign is_black = (kind_ff == KIND_BLACK);
   assign is_white = (kind_ff == KIND_WHITE);
   assign is_meas  = (kind_ff == KIND_MEASURE);
   assign is_calib = is_black || is_white;

   always_comb begin
      lo_cur  = chan_ok ? low_ff[idx]  : '0;
      hi_cur  = chan_ok ? high_ff[idx] : '0;
      thr_cur = chan_ok ? thr_ff[idx]  : '0;
      lo_new  = (is_black && (sample_ff < lo_cur)) ? sample_ff : lo_cur;
      hi_new  = (is_white && (sample_ff > hi_cur)) ? sample_ff : hi_cur;
      mid_sum = {1'b0, hi_new} + {1'b0, lo_new};
      // An out-of-range channel reports a cleared threshold, even for calibration.
      thr_new = (chan_ok && is_calib) ? mid_sum[SB:1] : thr_cur;
      err_new = chan_ok && (hi_new <= lo_new);
      diff    = (sample_ff >= lo_new) ? (sample_ff - lo_new) : (lo_new - sample_ff);
      dividend = QUO_BITS'(diff) * QUO_BITS'(FULL_SCALE);
   end

   always_comb begin
      status.need_div = chan_ok && is_meas && !err_new;
      status.out_free = !out_valid_ff || rsp_ready;
   end

   // One restoring divide step: the remainder always stays below the divisor.
   assign trial    = {rem_ff[SB-1:0], quo_ff[QUO_BITS-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});

   assign saturated = need_div_ff && (quo_ff > QUO_BITS'(FULL_SCALE));
   assign pct_fin   = !need_div_ff ? '0 :
                      saturated    ? FULL_SCALE : quo_ff[PERCENT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         chan_ff   <= req_channel;
         sample_ff <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            low_ff[c]  <= '0;
            high_ff[c] <= RST_HIGH;
            thr_ff[c]  <= RST_THR;
         end
      end else if (cmd.update && chan_ok && is_calib) begin
         low_ff[idx]  <= lo_new;
         high_ff[idx] <= hi_new;
         thr_ff[idx]  <= thr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         chan_ok_ff  <= chan_ok;
         on_ff       <= chan_ok && is_meas && (sample_ff > thr_cur);
         thr_res_ff  <= thr_new;
         err_ff      <= err_new;
         need_div_ff <= status.need_div;
         divisor_ff  <= hi_new - lo_new;
         rem_ff      <= '0;
         quo_ff      <= dividend;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? (trial - {1'b0, divisor_ff}) : trial;
         quo_ff <= {quo_ff[QUO_BITS-2:0], trial_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_chan_ok_ff <= chan_ok_ff;
         out_on_ff      <= on_ff;
         out_thr_ff     <= thr_res_ff;
         out_pct_ff     <= pct_fin;
         out_err_ff     <= err_ff || saturated;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_valid = out_chan_ok_ff;
   assign rsp_on_line       = out_on_ff;
   assign rsp_threshold     = out_thr_ff;
   assign rsp_percent       = out_pct_ff;
   assign rsp_range_error   = out_err_ff;

endmodule

`default_nettype wire

// File: design/line_sensor_calibrate_classify.sv
// Top level of the line-sensor calibrate/classify block.
// Depends on lscc_pkg, lscc_ifs (channel interfaces), lscc_ctrl and lscc_dp.
//
// Usage: each request beat carries a kind (black calibration, white
// calibration or measure), a channel index and a raw sample. Every request
// beat produces exactly one response beat with channel_valid, on_line,
// threshold, percent and range_error. Calibration beats widen the stored
// low/high marks of the channel and refresh its threshold; measure beats
// compare against the threshold and scale the sample into 0..100 percent.
// Timing: the block works on one beat at a time. A calibration beat, an
// unused kind or an out-of-range channel passes from capture through the
// update state to the finish state, which loads the response register. A
// measure beat also runs the shift-subtract divider between the update and
// finish states, one quotient bit a cycle. The next request is accepted
// as soon as the previous one has reached the response register, so a
// stalled receiver holds at most one finished beat while the next one is
// computed. When the receiver stalls longer, the finished beat waits in its
// final step and the request side stays not ready.
// Reset is synchronous: all lows become 0, all highs the full-scale mark and
// all thresholds its half, and no response is pending.
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_calibrate_classify #(
   parameter int CHANNELS    = lscc_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = lscc_pkg::SAMPLE_BITS_DEFAULT
) (
   input wire         clock,
   input wire         reset,
   lscc_req_if.sink   req_chan,
   lscc_rsp_if.source rsp_chan
);
   import lscc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   // The controller only needs the request valid; payload goes to the datapath.
   lscc_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   lscc_dp #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_chan.kind),
      .req_channel       (req_chan.channel),
      .req_sample        (req_chan.sample),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_channel_valid (rsp_chan.channel_valid),
      .rsp_on_line       (rsp_chan.on_line),
      .rsp_threshold     (rsp_chan.threshold),
      .rsp_percent       (rsp_chan.percent),
      .rsp_range_error   (rsp_chan.range_error)
   );

endmodule

`default_nettype wire
